FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BBA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define BBA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hdl/bba_pkg.sv
`timescale 1ns / 1ps
package bba_pkg;

	localparam int ORDER_CAP = 10;
	localparam int ORD_W     = 4;
	localparam int IDX_W     = 10;
	localparam int SIZE_W    = 11;
	localparam int WORD_W    = 32;
	localparam int BIT_W     = 5;
	localparam int MAP_DEPTH = 512;
	localparam int MAP_AW    = 9;

	// last row touched by the clearing sweep: orders 0..ORDER_CAP, 32 words each
	localparam logic [MAP_AW-1:0] SWEEP_LAST = 9'd351;
	localparam logic [SIZE_W-1:0] TOTAL_RESET = 11'd1024;
	localparam logic [SIZE_W-1:0] ARENA_MAX   = 11'd1024;

	localparam logic [1:0] CMD_ALLOC  = 2'd0;
	localparam logic [1:0] CMD_FREE   = 2'd1;
	localparam logic [1:0] CMD_INIT   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_NOFIT = 2'd1;
	localparam logic [1:0] STAT_BIG   = 2'd2;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [SIZE_W-1:0] size_in_blocks;
		logic [IDX_W-1:0]  block_index;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] granted_index;
	} rsp_t;

endpackage

FILE: hdl/buddy_block_allocator_unit.sv
`timescale 1ns / 1ps
// Buddy allocator with one free bitmap per order (0..10), held in a 512x32 map RAM
// addressed {order, word}. One command at a time; every command gives one response
// beat. After reset the block runs a clearing pass over the map rows of orders
// 0..10 and takes no request meanwhile. Initialize reruns that sweep, writing the
// greedy split as it goes. Allocate reads and checks one map word at a time, up to
// 68 words from the requested order to the top order, then reads and writes one
// map word per split level. Free reads and updates one map word per order visited:
// one per merge plus the final visit that marks the block free. A waiting response
// does not block accepting the next request; its response waits until the first is taken.
module buddy_block_allocator_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  bba_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output bba_pkg::rsp_t               rsp,
	input  logic                        cfg_we,
	input  logic [bba_pkg::SIZE_W-1:0]  cfg_wdata
);
	import bba_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_SWEEP    = 9'b000000010,
		S_SCAN_RD  = 9'b000000100,
		S_SCAN_CHK = 9'b000001000,
		S_SPLIT_RD = 9'b000010000,
		S_SPLIT_WR = 9'b000100000,
		S_FREE_RD  = 9'b001000000,
		S_FREE_CHK = 9'b010000000,
		S_DONE     = 9'b100000000
	} state_t;

	function automatic logic [ORD_W-1:0] ord_of(input logic [SIZE_W-1:0] s);
		logic [SIZE_W-1:0] m;
		logic [ORD_W-1:0]  r;
		m = s - 11'd1;
		r = '0;
		if (s > 11'd1) begin
			for (int k = 0; k < SIZE_W; k++) begin
				if (m[k]) r = ORD_W'(k + 1);
			end
		end
		return r;
	endfunction

	state_t             state_q;
	logic [MAP_AW-1:0]  sweep_q;
	logic               fill_q;
	logic [SIZE_W-1:0]  total_q;
	logic [ORD_W-1:0]   top_q;
	logic [ORD_W-1:0]   ord_q;
	logic [ORD_W-1:0]   tgt_q;
	logic [BIT_W-1:0]   word_q;
	logic [IDX_W-1:0]   blk_q;
	logic [1:0]         stat_q;
	logic [IDX_W-1:0]   grant_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               map_we;
	logic [MAP_AW-1:0]  map_waddr;
	logic [WORD_W-1:0]  map_wdata;
	logic [MAP_AW-1:0]  map_raddr;
	logic [WORD_W-1:0]  map_rdata;

	bba_ram #(.WIDTH(WORD_W), .DEPTH(MAP_DEPTH)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	// effective arena size and request decode
	logic [SIZE_W-1:0] arena;
	logic [ORD_W-1:0]  req_ord;
	logic [SIZE_W-1:0] req_sz;
	logic [IDX_W-1:0]  req_blk;
	assign arena   = (total_q > ARENA_MAX) ? ARENA_MAX : total_q;
	assign req_ord = ord_of(req.size_in_blocks);
	assign req_sz  = 11'd1 << req_ord;
	assign req_blk = req.block_index & ~IDX_W'(req_sz - 11'd1);

	// greedy split pattern for the sweep row
	logic [ORD_W-1:0]  sw_ord;
	logic [SIZE_W-1:0] sw_off;
	logic [SIZE_W-1:0] sw_k;
	logic [WORD_W-1:0] sw_data;
	assign sw_ord = sweep_q[MAP_AW-1:BIT_W];
	assign sw_off = (arena >> (sw_ord + 4'd1)) << (sw_ord + 4'd1);
	assign sw_k   = sw_off >> sw_ord;
	always_comb begin
		sw_data = '0;
		if (fill_q && arena[sw_ord] && sw_k[9:5] == sweep_q[BIT_W-1:0]) begin
			sw_data = WORD_W'(1) << sw_k[BIT_W-1:0];
		end
	end

	// lowest set bit of the scanned word
	logic [BIT_W-1:0] first_bit;
	always_comb begin
		first_bit = '0;
		for (int k = WORD_W - 1; k >= 0; k--) begin
			if (map_rdata[k]) first_bit = BIT_W'(k);
		end
	end

	logic [IDX_W-1:0] found_blk;
	logic [5:0]       nwords;
	logic             word_last;
	assign found_blk = IDX_W'({word_q, first_bit} << ord_q);
	assign nwords    = 6'd32 >> ord_q;
	assign word_last = (ord_q >= 4'd5) || (word_q == BIT_W'(nwords - 6'd1));

	// split target: upper half at the current split order
	logic [IDX_W-1:0] split_k;
	assign split_k = (grant_q >> ord_q) | 10'd1;

	// buddy check for free
	logic [IDX_W-1:0]  free_k;
	logic [IDX_W-1:0]  bud_k;
	logic [SIZE_W-1:0] ord_sz;
	logic [SIZE_W-1:0] bud;
	logic              merge;
	assign free_k = blk_q >> ord_q;
	assign bud_k  = free_k ^ 10'd1;
	assign ord_sz = 11'd1 << ord_q;
	assign bud    = {1'b0, blk_q} ^ ord_sz;
	assign merge  = (ord_q < 4'(ORDER_CAP))
		&& (({1'b0, bud} + {1'b0, ord_sz}) <= {1'b0, arena})
		&& map_rdata[bud_k[BIT_W-1:0]];

	// map port steering
	always_comb begin
		map_we    = 1'b0;
		map_waddr = '0;
		map_wdata = '0;
		map_raddr = '0;
		unique case (state_q)
			S_SWEEP: begin
				map_we    = 1'b1;
				map_waddr = sweep_q;
				map_wdata = sw_data;
			end
			S_SCAN_RD: begin
				map_raddr = {ord_q, word_q};
			end
			S_SCAN_CHK: begin
				map_we    = (map_rdata != '0);
				map_waddr = {ord_q, word_q};
				map_wdata = map_rdata & ~(WORD_W'(1) << first_bit);
			end
			S_SPLIT_RD: begin
				map_raddr = {ord_q, split_k[9:5]};
			end
			S_SPLIT_WR: begin
				map_we    = 1'b1;
				map_waddr = {ord_q, split_k[9:5]};
				map_wdata = map_rdata | (WORD_W'(1) << split_k[BIT_W-1:0]);
			end
			S_FREE_RD: begin
				map_raddr = {ord_q, free_k[9:5]};
			end
			S_FREE_CHK: begin
				map_we    = 1'b1;
				map_waddr = {ord_q, free_k[9:5]};
				map_wdata = merge ? (map_rdata & ~(WORD_W'(1) << bud_k[BIT_W-1:0]))
					: (map_rdata | (WORD_W'(1) << free_k[BIT_W-1:0]));
			end
			default: begin
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RESET;
		end else if (cfg_we) begin
			total_q <= cfg_wdata;
		end
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			sweep_q <= '0;
			fill_q  <= 1'b0;
			top_q   <= '0;
			ord_q   <= '0;
			tgt_q   <= '0;
			word_q  <= '0;
			blk_q   <= '0;
			stat_q  <= STAT_OK;
			grant_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						grant_q <= '0;
						stat_q  <= STAT_OK;
						state_q <= S_DONE;
						case (req.cmd)
							CMD_ALLOC: begin
								if (req_ord > top_q) begin
									stat_q <= STAT_BIG;
								end else begin
									ord_q   <= req_ord;
									tgt_q   <= req_ord;
									word_q  <= '0;
									state_q <= S_SCAN_RD;
								end
							end
							CMD_FREE: begin
								if (req_ord > top_q) begin
									stat_q <= STAT_BIG;
								end else if (({2'b0, req_blk} + {1'b0, req_sz})
										<= {1'b0, arena}) begin
									blk_q   <= req_blk;
									ord_q   <= req_ord;
									state_q <= S_FREE_RD;
								end
							end
							CMD_INIT: begin
								fill_q  <= 1'b1;
								sweep_q <= '0;
								top_q   <= ord_of(arena);
								state_q <= S_SWEEP;
							end
							default: begin
							end
						endcase
					end
				end
				S_SWEEP: begin
					sweep_q <= sweep_q + 9'd1;
					if (sweep_q == SWEEP_LAST) begin
						state_q <= fill_q ? S_DONE : S_IDLE;
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CHK;
				end
				S_SCAN_CHK: begin
					if (map_rdata != '0) begin
						grant_q <= found_blk;
						if (ord_q == tgt_q) begin
							state_q <= S_DONE;
						end else begin
							ord_q   <= ord_q - 4'd1;
							state_q <= S_SPLIT_RD;
						end
					end else if (word_last) begin
						if (ord_q == top_q) begin
							stat_q  <= STAT_NOFIT;
							state_q <= S_DONE;
						end else begin
							ord_q   <= ord_q + 4'd1;
							word_q  <= '0;
							state_q <= S_SCAN_RD;
						end
					end else begin
						word_q  <= word_q + 5'd1;
						state_q <= S_SCAN_RD;
					end
				end
				S_SPLIT_RD: begin
					state_q <= S_SPLIT_WR;
				end
				S_SPLIT_WR: begin
					if (ord_q == tgt_q) begin
						state_q <= S_DONE;
					end else begin
						ord_q   <= ord_q - 4'd1;
						state_q <= S_SPLIT_RD;
					end
				end
				S_FREE_RD: begin
					state_q <= S_FREE_CHK;
				end
				S_FREE_CHK: begin
					if (merge) begin
						blk_q   <= blk_q & ~ord_sz[IDX_W-1:0];
						ord_q   <= ord_q + 4'd1;
						state_q <= S_FREE_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// response beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response beat payload
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) begin
			rsp_q.status        <= stat_q;
			rsp_q.granted_index <= grant_q;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`BBA_ASSERT_IMP(a_grant_only_ok, clk, arst_n, rsp_valid && rsp.status != STAT_OK, rsp.granted_index == '0)
	`BBA_ASSERT_NXT(a_accept_leaves_idle, clk, arst_n, req_valid && req_ready, state_q != S_IDLE)
	`BBA_ASSERT_IMP(a_no_write_on_read, clk, arst_n, state_q == S_SCAN_RD || state_q == S_SPLIT_RD || state_q == S_FREE_RD, !map_we)
	`BBA_ASSERT_IMP(a_split_above_target, clk, arst_n, state_q == S_SPLIT_RD || state_q == S_SPLIT_WR, ord_q >= tgt_q)

endmodule

FILE: hdl/bba_ram.sv
`timescale 1ns / 1ps
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
